// ----- src/gtbrc_pkg.sv -----
// Package for the two-border reach counter.
// Holds the state and direction codes and the fixed field widths; depends on nothing.
`timescale 1ns / 1ps

package gtbrc_pkg;

    localparam int DIM_W   = 7;   // width of the row and column registers
    localparam int IN_H_W  = 16;  // width of the cell height field
    localparam int OUT_W   = 13;  // width of the result count field
    localparam int PADDR_W = 3;

    localparam logic [PADDR_W-1:0] ADDR_ROW_COUNT    = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_COLUMN_COUNT = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_SEED,
        ST_DQ_RD,
        ST_DQ_WAIT,
        ST_CUR_H,
        ST_NB_RD,
        ST_NB_EV,
        ST_COUNT,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN
    } t_dir;

endpackage

// ----- src/gtbrc_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gtbrc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                      o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Read-first: a read at the written address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/grid_two_border_reach_count_unit.sv -----
// Two-border reach counter, top level.
// Depends on gtbrc_pkg and gtbrc_ram.
`timescale 1ns / 1ps

// How to use this block:
// Heights arrive one word per cell in raster order on the input channel
// (i_in_valid / o_in_stall). A word is taken when o_in_stall is low. The word whose
// i_last_cell bit is set ends the grid; the grid size is the row and column
// registers in force at that word, written over the APB port while idle.
// After the last word the block runs two breadth-first floods, one from the
// top row and left column and one from the bottom row and right column, and
// then a counting sweep. The count of cells reached by both floods leaves as
// one word on the output channel (o_out_valid / i_out_stall).
// After the last word each flood seeds its border cells in one pass over
// the grid. Then for each queued cell it reads the queue entry and the
// cell's height and tests the four neighbors one at a time, reading the
// height and reach map of an in-grid neighbor and skipping an off-grid one,
// as the reach maps and heights each have a single read port. A flood ends
// when it finds its queue empty.
// After reset the block clears all MAX_ROWS * MAX_COLUMNS entries of both
// reach maps, one entry a cycle, and takes no input meanwhile. The sweep
// clears the maps again for the next grid. While the receiver stalls the
// result holds; further cells still load, but a new last word waits.
module grid_two_border_reach_count_unit #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [gtbrc_pkg::IN_H_W-1:0]   i_cell_height,
    input  logic                           i_last_cell,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gtbrc_pkg::OUT_W-1:0]    o_both_reach_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gtbrc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import gtbrc_pkg::*;

    localparam int CAP   = MAX_ROWS * MAX_COLUMNS;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int QW    = 2 * DIM_W + IDX_W;

    // Configuration registers.
    logic [DIM_W-1:0] r_row_count, r_column_count;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-DIM_W){1'b0}}, r_column_count}
                             : {{(32-DIM_W){1'b0}}, r_row_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= DIM_W'(1);
            r_column_count <= DIM_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_column_count <= pwdata[DIM_W-1:0];
            end else begin
                r_row_count <= pwdata[DIM_W-1:0];
            end
        end
    end

    // A zero register means one; a value above the maximum means the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int mx);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > mx) begin
            res = DIM_W'(mx);
        end
        return res;
    endfunction

    logic [DIM_W-1:0]   rows, cols;
    logic [2*DIM_W-1:0] prod;
    logic [CNT_W-1:0]   total;

    assign rows  = clamp_dim(r_row_count, MAX_ROWS);
    assign cols  = clamp_dim(r_column_count, MAX_COLUMNS);
    assign prod  = (2*DIM_W)'(rows) * (2*DIM_W)'(cols);
    assign total = CNT_W'(prod);

    // Control state.
    t_state           r_state, n_state;
    t_dir             r_dir, n_dir;
    logic             r_flood, n_flood;
    logic [CNT_W-1:0] r_load_pos, n_load_pos;
    logic [CNT_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0] r_lin, n_lin;
    logic [DIM_W-1:0] r_sr, n_sr, r_sc, n_sc;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rd_v, n_rd_v;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_out, n_out;

    // Payload of the cell under work and of the neighbor being tested.
    logic [DIM_W-1:0]       r_cr, n_cr, r_cc, n_cc, r_nr, n_nr, r_nc, n_nc;
    logic [IDX_W-1:0]       r_clin, n_clin, r_nlin, n_nlin;
    logic [HEIGHT_BITS-1:0] r_hcur, n_hcur;

    // Memory ports.
    logic                   h_we, m0_we, m1_we, m_wd, q_we;
    logic [IDX_W-1:0]       h_wa, h_ra, m_wa, m_ra, q_wa, q_ra;
    logic [HEIGHT_BITS-1:0] h_wd, h_rd;
    logic                   m0_rd, m1_rd;
    logic [QW-1:0]          q_wd, q_rd;

    logic [31:0]            h_ext;
    logic                   accept;
    logic                   seed;
    logic                   nb_ok;
    logic [DIM_W-1:0]       nb_r, nb_c;
    logic [IDX_W-1:0]       nb_lin;
    logic                   nb_seen;
    logic [CNT_W-1:0]       cnt_sum;

    assign h_ext = {{(32-IN_H_W){1'b0}}, i_cell_height};

    assign o_in_stall = (r_state != ST_LOAD) || (r_out_valid && i_last_cell);
    assign accept     = i_in_valid && !o_in_stall;

    assign seed = r_flood ? ((r_sr == rows - DIM_W'(1)) || (r_sc == cols - DIM_W'(1)))
                          : ((r_sr == '0) || (r_sc == '0));

    assign nb_seen = r_flood ? m1_rd : m0_rd;
    assign cnt_sum = r_count + CNT_W'(r_rd_v && m0_rd && m1_rd);

    // Neighbor of the current cell in the direction under test.
    always_comb begin
        nb_ok  = 1'b0;
        nb_r   = r_cr;
        nb_c   = r_cc;
        nb_lin = r_clin;
        case (r_dir)
            DIR_LEFT: begin
                nb_ok  = (r_cc != '0);
                nb_c   = r_cc - DIM_W'(1);
                nb_lin = r_clin - IDX_W'(1);
            end
            DIR_UP: begin
                nb_ok  = (r_cr != '0);
                nb_r   = r_cr - DIM_W'(1);
                nb_lin = IDX_W'(32'(r_clin) - 32'(cols));
            end
            DIR_RIGHT: begin
                nb_ok  = (r_cc != cols - DIM_W'(1));
                nb_c   = r_cc + DIM_W'(1);
                nb_lin = r_clin + IDX_W'(1);
            end
            DIR_DOWN: begin
                nb_ok  = (r_cr != rows - DIM_W'(1));
                nb_r   = r_cr + DIM_W'(1);
                nb_lin = IDX_W'(32'(r_clin) + 32'(cols));
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_flood     = r_flood;
        n_load_pos  = r_load_pos;
        n_head      = r_head;
        n_tail      = r_tail;
        n_lin       = r_lin;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_count     = r_count;
        n_rd_v      = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_cr        = r_cr;
        n_cc        = r_cc;
        n_nr        = r_nr;
        n_nc        = r_nc;
        n_clin      = r_clin;
        n_nlin      = r_nlin;
        n_hcur      = r_hcur;

        h_we  = 1'b0;
        h_wa  = r_load_pos[IDX_W-1:0];
        h_wd  = h_ext[HEIGHT_BITS-1:0];
        h_ra  = r_clin;
        m0_we = 1'b0;
        m1_we = 1'b0;
        m_wa  = r_lin[IDX_W-1:0];
        m_wd  = 1'b0;
        m_ra  = r_lin[IDX_W-1:0];
        q_we  = 1'b0;
        q_wa  = r_tail[IDX_W-1:0];
        q_wd  = {r_sr, r_sc, r_lin[IDX_W-1:0]};
        q_ra  = r_head[IDX_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                m0_we = 1'b1;
                m1_we = 1'b1;
                n_lin = r_lin + CNT_W'(1);
                if (r_lin == CNT_W'(CAP - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (accept) begin
                    if (r_load_pos < total) begin
                        h_we       = 1'b1;
                        n_load_pos = r_load_pos + CNT_W'(1);
                    end
                    if (i_last_cell) begin
                        n_load_pos = '0;
                        n_flood    = 1'b0;
                        n_head     = '0;
                        n_tail     = '0;
                        n_lin      = '0;
                        n_sr       = '0;
                        n_sc       = '0;
                        n_state    = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                if (seed) begin
                    m_wd   = 1'b1;
                    m0_we  = !r_flood;
                    m1_we  = r_flood;
                    q_we   = 1'b1;
                    n_tail = r_tail + CNT_W'(1);
                end
                n_lin = r_lin + CNT_W'(1);
                if (r_sc == cols - DIM_W'(1)) begin
                    n_sc = '0;
                    n_sr = r_sr + DIM_W'(1);
                end else begin
                    n_sc = r_sc + DIM_W'(1);
                end
                if (r_lin == total - CNT_W'(1)) begin
                    n_state = ST_DQ_RD;
                end
            end
            ST_DQ_RD: begin
                if (r_head == r_tail) begin
                    n_head = '0;
                    n_tail = '0;
                    n_lin  = '0;
                    n_sr   = '0;
                    n_sc   = '0;
                    if (!r_flood) begin
                        n_flood = 1'b1;
                        n_state = ST_SEED;
                    end else begin
                        n_count = '0;
                        n_state = ST_COUNT;
                    end
                end else begin
                    n_head  = r_head + CNT_W'(1);
                    n_state = ST_DQ_WAIT;
                end
            end
            ST_DQ_WAIT: begin
                n_cr    = q_rd[QW-1 -: DIM_W];
                n_cc    = q_rd[IDX_W +: DIM_W];
                n_clin  = q_rd[IDX_W-1:0];
                h_ra    = q_rd[IDX_W-1:0];
                n_state = ST_CUR_H;
            end
            ST_CUR_H: begin
                n_hcur  = h_rd;
                n_dir   = DIR_LEFT;
                n_state = ST_NB_RD;
            end
            ST_NB_RD: begin
                h_ra   = nb_lin;
                m_ra   = nb_lin;
                n_nr   = nb_r;
                n_nc   = nb_c;
                n_nlin = nb_lin;
                if (nb_ok) begin
                    n_state = ST_NB_EV;
                end else if (r_dir == DIR_DOWN) begin
                    n_state = ST_DQ_RD;
                end else begin
                    n_dir = t_dir'(r_dir + 2'd1);
                end
            end
            ST_NB_EV: begin
                if (!nb_seen && (h_rd >= r_hcur)) begin
                    m_wa   = r_nlin;
                    m_wd   = 1'b1;
                    m0_we  = !r_flood;
                    m1_we  = r_flood;
                    q_we   = 1'b1;
                    q_wd   = {r_nr, r_nc, r_nlin};
                    n_tail = r_tail + CNT_W'(1);
                end
                if (r_dir == DIR_DOWN) begin
                    n_state = ST_DQ_RD;
                end else begin
                    n_dir   = t_dir'(r_dir + 2'd1);
                    n_state = ST_NB_RD;
                end
            end
            ST_COUNT: begin
                // Read both maps and clear the entry in the same cycle.
                m0_we   = 1'b1;
                m1_we   = 1'b1;
                n_rd_v  = 1'b1;
                n_count = cnt_sum;
                n_lin   = r_lin + CNT_W'(1);
                if (r_lin == total - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_out       = cnt_sum;
                n_out_valid = 1'b1;
                n_lin       = '0;
                n_state     = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_dir       <= DIR_LEFT;
            r_flood     <= 1'b0;
            r_load_pos  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_lin       <= '0;
            r_sr        <= '0;
            r_sc        <= '0;
            r_count     <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_flood     <= n_flood;
            r_load_pos  <= n_load_pos;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_lin       <= n_lin;
            r_sr        <= n_sr;
            r_sc        <= n_sc;
            r_count     <= n_count;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_cr   <= n_cr;
        r_cc   <= n_cc;
        r_nr   <= n_nr;
        r_nc   <= n_nc;
        r_clin <= n_clin;
        r_nlin <= n_nlin;
        r_hcur <= n_hcur;
    end

    logic [31:0] out_ext;
    assign out_ext            = 32'(r_out);
    assign o_out_valid        = r_out_valid;
    assign o_both_reach_count = out_ext[OUT_W-1:0];

    gtbrc_ram #(.DATA_W(HEIGHT_BITS), .DEPTH(CAP)) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_wa),
        .i_wdata (h_wd),
        .i_raddr (h_ra),
        .o_rdata (h_rd)
    );

    gtbrc_ram #(.DATA_W(1), .DEPTH(CAP)) u_first_map_ram (
        .i_clk   (i_clk),
        .i_we    (m0_we),
        .i_waddr (m_wa),
        .i_wdata (m_wd),
        .i_raddr (m_ra),
        .o_rdata (m0_rd)
    );

    gtbrc_ram #(.DATA_W(1), .DEPTH(CAP)) u_second_map_ram (
        .i_clk   (i_clk),
        .i_we    (m1_we),
        .i_waddr (m_wa),
        .i_wdata (m_wd),
        .i_raddr (m_ra),
        .o_rdata (m1_rd)
    );

    gtbrc_ram #(.DATA_W(QW), .DEPTH(CAP)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_wa),
        .i_wdata (q_wd),
        .i_raddr (q_ra),
        .o_rdata (q_rd)
    );

endmodule

// ----- src/gtbrc_checker.sv -----
// Port-level checker for the two-border reach counter, with its bind statement.
// Depends on gtbrc_pkg and the top-level port list.
`timescale 1ns / 1ps

module gtbrc_checker #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_last_cell,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [gtbrc_pkg::OUT_W-1:0]  o_both_reach_count
);
    import gtbrc_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_both_reach_count))
        else $error("result changed while stalled");

    // The count never exceeds the grid capacity, MAX_ROWS * MAX_COLUMNS.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_both_reach_count) <= MAX_ROWS * MAX_COLUMNS)
        else $error("count above grid capacity");

    // One result per grid: a taken result is not followed at once by another.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("result repeated");

    // The last word of a grid starts computing; no result is shown right after.
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_cell |=> !o_out_valid && o_in_stall)
        else $error("last word did not start computation");

endmodule

bind grid_two_border_reach_count_unit gtbrc_checker #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
) u_gtbrc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_last_cell        (i_last_cell),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_both_reach_count (o_both_reach_count)
);

// ----- test/grid_reach_checker.sv -----
// Checker for the two-border reach counter: watches the input and output channels,
// predicts the both-border reach count per grid and compares. Depends on gtbrc_pkg.
`timescale 1ns / 1ps

module grid_reach_checker #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [gtbrc_pkg::IN_H_W-1:0]  cell_height,
    input  logic                          last_cell,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [gtbrc_pkg::OUT_W-1:0]   both_reach_count,
    input  logic [gtbrc_pkg::DIM_W-1:0]   row_reg,
    input  logic [gtbrc_pkg::DIM_W-1:0]   col_reg,
    output int                            fail_count,
    output int                            pending_count,
    output int                            results_seen
);
    localparam int CELLS = MAX_ROWS * MAX_COLUMNS;

    logic [15:0] heights [CELLS];
    bit          near_map [CELLS];
    bit          far_map [CELLS];
    int          flood_queue [CELLS];
    int          load_pos;
    logic [gtbrc_pkg::OUT_W-1:0] expected_counts [$];

    function automatic int clamp_dim(input logic [gtbrc_pkg::DIM_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic flood_from(input bit far_side, input int rows, input int cols);
        int head, tail, cur, cr, cc, nr, nc, nidx, k;
        int dr [4];
        int dc [4];
        dr = '{0, -1, 0, 1};
        dc = '{-1, 0, 1, 0};
        head = 0;
        tail = 0;
        for (int i = 0; i < CELLS; i++) begin
            if (far_side) far_map[i] = 0;
            else near_map[i] = 0;
        end
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (far_side ? (r == rows - 1 || c == cols - 1) : (r == 0 || c == 0)) begin
                    if (far_side) far_map[r * cols + c] = 1;
                    else near_map[r * cols + c] = 1;
                    flood_queue[tail++] = r * cols + c;
                end
            end
        end
        while (head < tail) begin
            cur = flood_queue[head++];
            cr = cur / cols;
            cc = cur % cols;
            for (k = 0; k < 4; k++) begin
                nr = cr + dr[k];
                nc = cc + dc[k];
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                nidx = nr * cols + nc;
                if (far_side ? far_map[nidx] : near_map[nidx]) continue;
                if (heights[nidx] >= heights[cur]) begin
                    if (far_side) far_map[nidx] = 1;
                    else near_map[nidx] = 1;
                    flood_queue[tail++] = nidx;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        load_pos = 0;
        for (int i = 0; i < CELLS; i++) heights[i] = '0;
    end

    assign pending_count = expected_counts.size();

    always @(posedge i_clk) begin
        int rows, cols, total;
        logic [gtbrc_pkg::OUT_W-1:0] want;
        if (i_rst_n && in_valid && !in_stall) begin
            rows = clamp_dim(row_reg, MAX_ROWS);
            cols = clamp_dim(col_reg, MAX_COLUMNS);
            if (load_pos < rows * cols) begin
                heights[load_pos] = cell_height;
                load_pos++;
            end
            if (last_cell) begin
                flood_from(0, rows, cols);
                flood_from(1, rows, cols);
                total = 0;
                for (int i = 0; i < rows * cols; i++)
                    if (near_map[i] && far_map[i]) total++;
                expected_counts.push_back(total[gtbrc_pkg::OUT_W-1:0]);
                load_pos = 0;
            end
        end
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected count %0d", both_reach_count));
            end else begin
                want = expected_counts.pop_front();
                if (both_reach_count !== want)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              both_reach_count, want));
            end
        end
    end
endmodule

// ----- test/grid_two_border_reach_count_unit_tb.sv -----
// Testbench top for the two-border reach counter: drives grids and APB writes,
// gives the verdict. Depends on gtbrc_pkg, the block and grid_reach_checker.
`timescale 1ns / 1ps

module grid_two_border_reach_count_unit_tb;
    import gtbrc_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, i_last_cell;
    logic [IN_H_W-1:0] i_cell_height;
    logic o_out_valid, i_out_stall;
    logic [OUT_W-1:0] o_both_reach_count;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    // Shadow copies of the registers, used by the checker at each accepted word.
    logic [DIM_W-1:0] row_shadow, col_shadow;

    int fail_count, pending_count, results_seen;
    int send_idle_pct, recv_stall_pct;
    int words_sent, grids_sent, cycle_count;
    // Heights are drawn from a range per grid so that floods both spread and stop.
    int height_span;

    grid_two_border_reach_count_unit uut (.*);

    grid_reach_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_valid(i_in_valid), .in_stall(o_in_stall),
        .cell_height(i_cell_height), .last_cell(i_last_cell),
        .out_valid(o_out_valid), .out_stall(i_out_stall),
        .both_reach_count(o_both_reach_count),
        .row_reg(row_shadow), .col_reg(col_shadow),
        .fail_count(fail_count), .pending_count(pending_count),
        .results_seen(results_seen)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter doubles as the watchdog.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[grid_two_border_reach_count_unit] ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One APB write: setup cycle then access cycle; pready is always high.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        if (addr == ADDR_ROW_COUNT) row_shadow = value;
        else col_shadow = value;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_grid_size(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
        apb_write(ADDR_ROW_COUNT, rows);
        apb_write(ADDR_COLUMN_COUNT, cols);
    endtask

    // Sends one word, holding it until accepted; called at a falling edge.
    // Words that follow each other drop valid and raise it again in the same
    // step, so these drives are immediate.
    task automatic send_word(input logic [IN_H_W-1:0] height, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_cell_height = height;
        i_last_cell = last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 0;
        words_sent++;
    endtask

    function automatic int grid_cells();
        int r, c;
        r = (row_shadow == 0) ? 1 : (row_shadow > 64 ? 64 : row_shadow);
        c = (col_shadow == 0) ? 1 : (col_shadow > 64 ? 64 : col_shadow);
        return r * c;
    endfunction

    // Full grid with random heights; extra words beyond the grid are optional.
    task automatic send_grid(input int extra);
        int n;
        n = grid_cells();
        for (int i = 0; i < n + extra; i++)
            send_word(IN_H_W'($urandom_range(height_span)), i == n + extra - 1);
        grids_sent++;
    endtask

    // Waits until every expected count has come back, then lets the block settle.
    task automatic drain();
        while (pending_count != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_phase(input int grids);
        for (int g = 0; g < grids; g++) begin
            if ($urandom_range(7) == 0) begin
                drain();
                set_grid_size(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
            end
            height_span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 6);
            send_grid(($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0; i_cell_height = 0; i_last_cell = 0; i_out_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        row_shadow = 1; col_shadow = 1;
        send_idle_pct = 0; recv_stall_pct = 0;
        words_sent = 0; grids_sent = 0; height_span = 65535;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: one cell grid at the height extremes, all height bits clear and then all set.
        send_word(16'h0000, 1);
        send_word(16'hFFFF, 1);
        grids_sent += 2;
        // Zero registers are taken as one; oversize ones as the maximum.
        drain();
        set_grid_size('0, '0);
        send_word(16'h5555, 1);
        send_word(16'hAAAA, 1);
        grids_sent += 2;
        drain();
        set_grid_size(3, 3);
        height_span = 65535;
        send_grid(0);
        // Extra cells after a full grid are ignored; the last one still triggers.
        send_grid(2);
        // Early last cell reuses heights of the previous grid, all written already.
        send_word(16'd7, 0);
        send_word(16'd3, 1);
        grids_sent++;
        drain();
        set_grid_size(7'd127, 7'd1);
        height_span = 3;
        send_grid(0);
        drain();
        set_grid_size(7'd64, 7'd1);
        send_grid(0);
        drain();
        set_grid_size(7'd1, 7'd64);
        send_grid(0);
        drain();
        set_grid_size(2, 5);

        // Random phases: none, sender idle, receiver stall, both.
        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(20);
        send_idle_pct = 67; recv_stall_pct = 0;  random_phase(20);
        drain();
        send_idle_pct = 0;  recv_stall_pct = 67; random_phase(20);
        send_idle_pct = 28; recv_stall_pct = 28; random_phase(20);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(10);

        drain();
        repeat (200) @(negedge i_clk);
        $display("sent %0d words in %0d grids, %0d counts checked, %0d mismatches",
                 words_sent, grids_sent, results_seen, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("[grid_two_border_reach_count_unit] OK");
        else
            $display("[grid_two_border_reach_count_unit] ERROR");
        $finish;
    end
endmodule
